// ===== rtl/mkcd_pkg.sv =====
// Shared types and constants for the multi-key click event detector.
`default_nettype none
package mkcd_pkg;

  localparam int FLAG_W     = 7;
  localparam int TIMER_W    = 16;
  localparam int DIV_W      = 8;
  localparam int PIN_W      = 4;
  localparam int KEY_IDX_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FLAG_HOLD   = 0;
  localparam int FLAG_DOWN   = 1;
  localparam int FLAG_UP     = 2;
  localparam int FLAG_SINGLE = 3;
  localparam int FLAG_DOUBLE = 4;
  localparam int FLAG_LONG   = 5;
  localparam int FLAG_REPEAT = 6;

  localparam logic [FLAG_W-1:0] HOLD_ONLY_MASK = 7'h01;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 3'd4;

  localparam logic [DIV_W-1:0]   RST_SAMPLE_DIV = 8'd20;
  localparam logic [TIMER_W-1:0] RST_LONG_TICKS = 16'd2000;
  localparam logic [TIMER_W-1:0] RST_DBL_TICKS  = 16'd200;
  localparam logic [TIMER_W-1:0] RST_RPT_TICKS  = 16'd100;
  localparam logic [PIN_W-1:0]   RST_ACTIVE_LOW = 4'd3;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_RELEASED = 3'd2,
    PH_SECOND   = 3'd3,
    PH_LONG     = 3'd4
  } phase_e;

  typedef struct packed {
    logic              tick;
    logic              sample;
    logic              cur;
    logic              clear;
    logic [FLAG_W-1:0] clr_mask;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/mkcd_lane.sv =====
// One key lane: pressed bit, phase machine, window timer and event flags.
`default_nettype none
module mkcd_lane (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mkcd_pkg::lane_ctrl_t            ctrl_i,
  input  wire logic [mkcd_pkg::TIMER_W-1:0]    long_ticks_i,
  input  wire logic [mkcd_pkg::TIMER_W-1:0]    double_ticks_i,
  input  wire logic [mkcd_pkg::TIMER_W-1:0]    repeat_ticks_i,
  output logic      [mkcd_pkg::FLAG_W-1:0]     flags_o
);

  mkcd_pkg::phase_e                  phase_q, phase_d;
  logic [mkcd_pkg::TIMER_W-1:0]      timer_q, timer_d, timer_dec;
  logic                              pressed_q, pressed_d;
  logic [mkcd_pkg::FLAG_W-1:0]       flags_q, flags_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mkcd_pkg::PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q   <= '0;
      pressed_q <= 1'b0;
      flags_q   <= '0;
    end else begin
      timer_q   <= timer_d;
      pressed_q <= pressed_d;
      flags_q   <= flags_d;
    end
  end

  assign timer_dec = (timer_q == '0) ? timer_q : timer_q - 1'b1;

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    pressed_d = pressed_q;
    flags_d   = flags_q;
    if (ctrl_i.tick) begin
      timer_d = timer_dec;
      if (ctrl_i.sample) begin
        pressed_d = ctrl_i.cur;
        flags_d[mkcd_pkg::FLAG_HOLD] = ctrl_i.cur;
        if (ctrl_i.cur && !pressed_q) begin
          flags_d[mkcd_pkg::FLAG_DOWN] = 1'b1;
        end
        if (!ctrl_i.cur && pressed_q) begin
          flags_d[mkcd_pkg::FLAG_UP] = 1'b1;
        end
        case (phase_q)
          mkcd_pkg::PH_PRESSED: begin
            if (!ctrl_i.cur) begin
              timer_d = double_ticks_i;
              phase_d = mkcd_pkg::PH_RELEASED;
            end else if (timer_dec == '0) begin
              timer_d = repeat_ticks_i;
              flags_d[mkcd_pkg::FLAG_LONG] = 1'b1;
              phase_d = mkcd_pkg::PH_LONG;
            end
          end
          mkcd_pkg::PH_RELEASED: begin
            if (ctrl_i.cur) begin
              flags_d[mkcd_pkg::FLAG_DOUBLE] = 1'b1;
              phase_d = mkcd_pkg::PH_SECOND;
            end else if (timer_dec == '0) begin
              flags_d[mkcd_pkg::FLAG_SINGLE] = 1'b1;
              phase_d = mkcd_pkg::PH_IDLE;
            end
          end
          mkcd_pkg::PH_SECOND: begin
            if (!ctrl_i.cur) begin
              phase_d = mkcd_pkg::PH_IDLE;
            end
          end
          mkcd_pkg::PH_LONG: begin
            if (!ctrl_i.cur) begin
              phase_d = mkcd_pkg::PH_IDLE;
            end else if (timer_dec == '0) begin
              timer_d = repeat_ticks_i;
              flags_d[mkcd_pkg::FLAG_REPEAT] = 1'b1;
            end
          end
          default: begin
            if (ctrl_i.cur) begin
              timer_d = long_ticks_i;
              phase_d = mkcd_pkg::PH_PRESSED;
            end
          end
        endcase
      end
    end else if (ctrl_i.clear) begin
      flags_d = flags_q & ~ctrl_i.clr_mask;
    end
  end

  assign flags_o = flags_q;

  a_phase_holds_between_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.tick && ctrl_i.sample) |=> $stable(phase_q))
    else $error("phase changed without a sample");

  a_clear_drops_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.clear && !ctrl_i.tick) |=> ((flags_q & $past(ctrl_i.clr_mask)) == '0))
    else $error("cleared flags still set");

  a_hold_follows_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.tick && ctrl_i.sample) |=>
      (flags_q[mkcd_pkg::FLAG_HOLD] == pressed_q))
    else $error("hold flag disagrees with pressed state");

endmodule
`default_nettype wire

// ===== rtl/mkcd_merge.sv =====
// Merge stage: select the checked key's flags and test them against the request.
`default_nettype none
module mkcd_merge #(
  parameter int KEYS = 4
) (
  input  wire logic [mkcd_pkg::FLAG_W-1:0]    lane_flags_i [KEYS],
  input  wire logic [mkcd_pkg::KEY_IDX_W-1:0] key_index_i,
  input  wire logic [mkcd_pkg::FLAG_W-1:0]    flag_mask_i,
  output logic      [KEYS-1:0]                key_sel_o,
  output logic                                found_o,
  output logic      [mkcd_pkg::FLAG_W-1:0]    flags_seen_o
);

  always_comb begin
    flags_seen_o = '0;
    for (int k = 0; k < KEYS; k++) begin
      key_sel_o[k] = (32'(key_index_i) == k);
      if (key_sel_o[k]) begin
        flags_seen_o = flags_seen_o | lane_flags_i[k];
      end
    end
    found_o = |(flags_seen_o & flag_mask_i);
  end

endmodule
`default_nettype wire

// ===== rtl/multi_key_click_event_detector.sv =====
// Top level of the multi-key click event detector: config, divider, lanes, result register.
// A tick updates all KEYS lanes side by side (timer count-down, sampling and phase machine
// in one step per lane) and a check selects one lane's flags and, on a hit with a mask other
// than hold-only, clears the requested ones. Each request gives one result, held in an
// output register; a new request is taken whenever that register is empty or being read,
// so the block sustains one request per cycle.
`default_nettype none
module multi_key_click_event_detector #(
  parameter int KEYS = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mkcd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mkcd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                kind_i,
  input  wire logic [mkcd_pkg::PIN_W-1:0]          pin_levels_i,
  input  wire logic [mkcd_pkg::KEY_IDX_W-1:0]      key_index_i,
  input  wire logic [mkcd_pkg::FLAG_W-1:0]         flag_mask_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     found_o,
  output logic      [mkcd_pkg::FLAG_W-1:0]         flags_seen_o
);

  logic [mkcd_pkg::DIV_W-1:0]   sample_div_q;
  logic [mkcd_pkg::TIMER_W-1:0] long_ticks_q, dbl_ticks_q, rpt_ticks_q;
  logic [mkcd_pkg::PIN_W-1:0]   active_low_q;
  logic [mkcd_pkg::DIV_W-1:0]   div_cnt_q, div_cnt_d, div_inc;
  logic                         out_valid_q;
  logic                         found_q;
  logic [mkcd_pkg::FLAG_W-1:0]  flags_seen_q;
  logic                         accept, is_tick, is_check, do_sample, do_clear;
  logic [KEYS-1:0]              key_sel;
  logic                         hit;
  logic [mkcd_pkg::FLAG_W-1:0]  sel_flags;
  logic [mkcd_pkg::FLAG_W-1:0]  lane_flags [KEYS];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = accept && (kind_i == mkcd_pkg::KIND_TICK);
  assign is_check   = accept && (kind_i == mkcd_pkg::KIND_CHECK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_div_q <= mkcd_pkg::RST_SAMPLE_DIV;
      long_ticks_q <= mkcd_pkg::RST_LONG_TICKS;
      dbl_ticks_q  <= mkcd_pkg::RST_DBL_TICKS;
      rpt_ticks_q  <= mkcd_pkg::RST_RPT_TICKS;
      active_low_q <= mkcd_pkg::RST_ACTIVE_LOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mkcd_pkg::CFG_SAMPLE_DIV: sample_div_q <= cfg_wdata_i[mkcd_pkg::DIV_W-1:0];
        mkcd_pkg::CFG_LONG_TICKS: long_ticks_q <= cfg_wdata_i;
        mkcd_pkg::CFG_DBL_TICKS:  dbl_ticks_q  <= cfg_wdata_i;
        mkcd_pkg::CFG_RPT_TICKS:  rpt_ticks_q  <= cfg_wdata_i;
        mkcd_pkg::CFG_ACTIVE_LOW: active_low_q <= cfg_wdata_i[mkcd_pkg::PIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign div_inc   = div_cnt_q + 1'b1;
  assign do_sample = (div_inc >= sample_div_q);

  always_comb begin
    div_cnt_d = div_cnt_q;
    if (is_tick) begin
      div_cnt_d = do_sample ? '0 : div_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else begin
      div_cnt_q <= div_cnt_d;
    end
  end

  mkcd_merge #(
    .KEYS (KEYS)
  ) u_merge (
    .lane_flags_i (lane_flags),
    .key_index_i  (key_index_i),
    .flag_mask_i  (flag_mask_i),
    .key_sel_o    (key_sel),
    .found_o      (hit),
    .flags_seen_o (sel_flags)
  );

  assign do_clear = is_check && hit && (flag_mask_i != mkcd_pkg::HOLD_ONLY_MASK);

  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    mkcd_pkg::lane_ctrl_t ctrl;
    logic                 cur;

    if (k < mkcd_pkg::PIN_W) begin : g_pin
      assign cur = pin_levels_i[k] ^ active_low_q[k];
    end else begin : g_no_pin
      assign cur = 1'b0;
    end

    assign ctrl.tick     = is_tick;
    assign ctrl.sample   = do_sample;
    assign ctrl.cur      = cur;
    assign ctrl.clear    = do_clear && key_sel[k];
    assign ctrl.clr_mask = flag_mask_i;

    mkcd_lane u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .long_ticks_i   (long_ticks_q),
      .double_ticks_i (dbl_ticks_q),
      .repeat_ticks_i (rpt_ticks_q),
      .flags_o        (lane_flags[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q      <= is_check && hit;
      flags_seen_q <= is_check ? sel_flags : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign flags_seen_o = flags_seen_q;

endmodule
`default_nettype wire
